### hdl/cam_pkg.sv
// ----------------------------------------------------------------------------
// cam_pkg
// shared types, constants and round functions of the camellia cipher
// ----------------------------------------------------------------------------
package cam_pkg;

  localparam int NUM_SUBKEYS = 34;
  localparam int KW_AT       = 0;
  localparam int K_AT        = 4;
  localparam int KE_AT       = 28;
  localparam int NUM_ROUNDS  = 24;

  // configuration register indexes
  localparam logic [2:0] CFG_KEY0 = 3'd0;
  localparam logic [2:0] CFG_KEY1 = 3'd1;
  localparam logic [2:0] CFG_KEY2 = 3'd2;
  localparam logic [2:0] CFG_KEY3 = 3'd3;
  localparam logic [2:0] CFG_SIZE = 3'd4;

  localparam logic [1:0] SIZE_128 = 2'd0;
  localparam logic [1:0] SIZE_192 = 2'd1;

  typedef logic [63:0] subkey_arr_t [NUM_SUBKEYS];

  typedef struct packed {
    logic busy;
    logic long_key;
  } ks_stat_t;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_LOAD,
    KS_ROUND,
    KS_STORE
  } ks_state_t;

  localparam logic [63:0] KEY_CONST [6] = '{
    64'hA09E667F3BCC908B, 64'hB67AE8584CAA73B2, 64'hC6EF372FE94F82BE,
    64'h54FF53A5F1D36F1C, 64'h10E527FADE682D1D, 64'hB05688C2B3E6C1FD
  };

  localparam logic [7:0] SBOX [256] = '{
    8'd112,8'd130,8'd44,8'd236,8'd179,8'd39,8'd192,8'd229,
    8'd228,8'd133,8'd87,8'd53,8'd234,8'd12,8'd174,8'd65,
    8'd35,8'd239,8'd107,8'd147,8'd69,8'd25,8'd165,8'd33,
    8'd237,8'd14,8'd79,8'd78,8'd29,8'd101,8'd146,8'd189,
    8'd134,8'd184,8'd175,8'd143,8'd124,8'd235,8'd31,8'd206,
    8'd62,8'd48,8'd220,8'd95,8'd94,8'd197,8'd11,8'd26,
    8'd166,8'd225,8'd57,8'd202,8'd213,8'd71,8'd93,8'd61,
    8'd217,8'd1,8'd90,8'd214,8'd81,8'd86,8'd108,8'd77,
    8'd139,8'd13,8'd154,8'd102,8'd251,8'd204,8'd176,8'd45,
    8'd116,8'd18,8'd43,8'd32,8'd240,8'd177,8'd132,8'd153,
    8'd223,8'd76,8'd203,8'd194,8'd52,8'd126,8'd118,8'd5,
    8'd109,8'd183,8'd169,8'd49,8'd209,8'd23,8'd4,8'd215,
    8'd20,8'd88,8'd58,8'd97,8'd222,8'd27,8'd17,8'd28,
    8'd50,8'd15,8'd156,8'd22,8'd83,8'd24,8'd242,8'd34,
    8'd254,8'd68,8'd207,8'd178,8'd195,8'd181,8'd122,8'd145,
    8'd36,8'd8,8'd232,8'd168,8'd96,8'd252,8'd105,8'd80,
    8'd170,8'd208,8'd160,8'd125,8'd161,8'd137,8'd98,8'd151,
    8'd84,8'd91,8'd30,8'd149,8'd224,8'd255,8'd100,8'd210,
    8'd16,8'd196,8'd0,8'd72,8'd163,8'd247,8'd117,8'd219,
    8'd138,8'd3,8'd230,8'd218,8'd9,8'd63,8'd221,8'd148,
    8'd135,8'd92,8'd131,8'd2,8'd205,8'd74,8'd144,8'd51,
    8'd115,8'd103,8'd246,8'd243,8'd157,8'd127,8'd191,8'd226,
    8'd82,8'd155,8'd216,8'd38,8'd200,8'd55,8'd198,8'd59,
    8'd129,8'd150,8'd111,8'd75,8'd19,8'd190,8'd99,8'd46,
    8'd233,8'd121,8'd167,8'd140,8'd159,8'd110,8'd188,8'd142,
    8'd41,8'd245,8'd249,8'd182,8'd47,8'd253,8'd180,8'd89,
    8'd120,8'd152,8'd6,8'd106,8'd231,8'd70,8'd113,8'd186,
    8'd212,8'd37,8'd171,8'd66,8'd136,8'd162,8'd141,8'd250,
    8'd114,8'd7,8'd185,8'd85,8'd248,8'd238,8'd172,8'd10,
    8'd54,8'd73,8'd42,8'd104,8'd60,8'd56,8'd241,8'd164,
    8'd64,8'd40,8'd211,8'd123,8'd187,8'd201,8'd67,8'd193,
    8'd21,8'd227,8'd173,8'd244,8'd119,8'd199,8'd128,8'd158
  };

  function automatic logic [7:0] rl1(input logic [7:0] b);
    return {b[6:0], b[7]};
  endfunction

  function automatic logic [7:0] rr1(input logic [7:0] b);
    return {b[0], b[7:1]};
  endfunction

  // feistel round function: key add, s-boxes, byte diffusion
  function automatic logic [63:0] cam_f(input logic [63:0] x, input logic [63:0] k);
    logic [63:0] y;
    logic [7:0]  t0, t1, t2, t3, t4, t5, t6, t7;
    logic [7:0]  z0, z1, z2, z3, z4, z5, z6, z7;
    y  = x ^ k;
    t0 = SBOX[y[63:56]];
    t1 = rl1(SBOX[y[55:48]]);
    t2 = rr1(SBOX[y[47:40]]);
    t3 = SBOX[rl1(y[39:32])];
    t4 = rl1(SBOX[y[31:24]]);
    t5 = rr1(SBOX[y[23:16]]);
    t6 = SBOX[rl1(y[15:8])];
    t7 = SBOX[y[7:0]];
    z0 = t0 ^ t2 ^ t3 ^ t5 ^ t6 ^ t7;
    z1 = t0 ^ t1 ^ t3 ^ t4 ^ t6 ^ t7;
    z2 = t0 ^ t1 ^ t2 ^ t4 ^ t5 ^ t7;
    z3 = t1 ^ t2 ^ t3 ^ t4 ^ t5 ^ t6;
    z4 = t0 ^ t1 ^ t5 ^ t6 ^ t7;
    z5 = t1 ^ t2 ^ t4 ^ t6 ^ t7;
    z6 = t2 ^ t3 ^ t4 ^ t5 ^ t7;
    z7 = t0 ^ t3 ^ t4 ^ t5 ^ t6;
    return {z0, z1, z2, z3, z4, z5, z6, z7};
  endfunction

  function automatic logic [63:0] fl_fwd(input logic [63:0] x, input logic [63:0] k);
    logic [31:0] a, b, m;
    a = x[63:32];
    b = x[31:0];
    m = a & k[63:32];
    b = b ^ {m[30:0], m[31]};
    a = a ^ (b | k[31:0]);
    return {a, b};
  endfunction

  function automatic logic [63:0] fl_back(input logic [63:0] x, input logic [63:0] k);
    logic [31:0] a, b, m;
    a = x[63:32];
    b = x[31:0];
    a = a ^ (b | k[31:0]);
    m = a & k[63:32];
    b = b ^ {m[30:0], m[31]};
    return {a, b};
  endfunction

  // constant rotation of a 128-bit key half, pure wiring
  function automatic logic [127:0] rot128(input logic [127:0] v, input int unsigned n);
    logic [127:0] r;
    if (n == 0) begin
      r = v;
    end else begin
      r = (v << n) | (v >> (128 - n));
    end
    return r;
  endfunction

endpackage

### hdl/cam_key_sched.sv
// ----------------------------------------------------------------------------
// cam_key_sched
// key registers and subkey derivation, one f-function per cycle
// ----------------------------------------------------------------------------
module cam_key_sched (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output cam_pkg::ks_stat_t   stat,
  output cam_pkg::subkey_arr_t subkey
);
  import cam_pkg::*;

  localparam logic [2:0] STEP_FOLD_L    = 3'd1;
  localparam logic [2:0] STEP_CAPTURE_A = 3'd3;
  localparam logic [2:0] STEP_LAST      = 3'd5;

  ks_state_t   state_r, state_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [63:0] key0_r, key1_r, key2_r, key3_r;
  logic [1:0]  size_r;
  logic [63:0] d1_r, d2_r;
  logic [63:0] ah_r, al_r, bh_r, bl_r;
  logic [63:0] rh, rl;
  logic [63:0] f_out;
  logic        cfg_hit;
  subkey_arr_t sk_r, sk_nxt;
  logic [127:0] lk, rk, ak, bk;

  assign cfg_hit = cfg_we && (cfg_index <= CFG_SIZE);

  always_comb begin
    priority if (size_r == SIZE_128) begin
      rh = '0;
      rl = '0;
    end else if (size_r == SIZE_192) begin
      rh = key2_r;
      rl = ~key2_r;
    end else begin
      rh = key2_r;
      rl = key3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
      size_r <= SIZE_128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY0: key0_r <= cfg_data;
        CFG_KEY1: key1_r <= cfg_data;
        CFG_KEY2: key2_r <= cfg_data;
        CFG_KEY3: key3_r <= cfg_data;
        CFG_SIZE: size_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // shared f unit: even steps take d1 as input, odd steps take d2
  assign f_out = cam_f(step_r[0] ? d2_r : d1_r, KEY_CONST[step_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KS_LOAD;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      KS_IDLE: ;
      KS_LOAD: begin
        state_nxt = KS_ROUND;
        step_nxt  = '0;
      end
      KS_ROUND: begin
        step_nxt = step_r + 3'd1;
        if (step_r == STEP_LAST) begin
          state_nxt = KS_STORE;
        end
      end
      KS_STORE: state_nxt = KS_IDLE;
      default: state_nxt = KS_IDLE;
    endcase
    if (cfg_hit) begin
      state_nxt = KS_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == KS_LOAD) begin
      d1_r <= key0_r ^ rh;
      d2_r <= key1_r ^ rl;
    end else if (state_r == KS_ROUND) begin
      if (!step_r[0]) begin
        d2_r <= d2_r ^ f_out;
      end else if (step_r == STEP_FOLD_L) begin
        d1_r <= d1_r ^ f_out ^ key0_r;
        d2_r <= d2_r ^ key1_r;
      end else if (step_r == STEP_CAPTURE_A) begin
        ah_r <= d1_r ^ f_out;
        al_r <= d2_r;
        d1_r <= d1_r ^ f_out ^ rh;
        d2_r <= d2_r ^ rl;
      end else begin
        bh_r <= d1_r ^ f_out;
        bl_r <= d2_r;
      end
    end
  end

  assign lk = {key0_r, key1_r};
  assign rk = {rh, rl};
  assign ak = {ah_r, al_r};
  assign bk = {bh_r, bl_r};

  always_comb begin
    logic [127:0] r;
    for (int i = 0; i < NUM_SUBKEYS; i++) begin
      sk_nxt[i] = '0;
    end
    sk_nxt[KW_AT]     = key0_r;
    sk_nxt[KW_AT + 1] = key1_r;
    if (size_r == SIZE_128) begin
      {sk_nxt[K_AT],      sk_nxt[K_AT + 1]}  = ak;
      {sk_nxt[K_AT + 2],  sk_nxt[K_AT + 3]}  = rot128(lk, 15);
      {sk_nxt[K_AT + 4],  sk_nxt[K_AT + 5]}  = rot128(ak, 15);
      {sk_nxt[KE_AT],     sk_nxt[KE_AT + 1]} = rot128(ak, 30);
      {sk_nxt[K_AT + 6],  sk_nxt[K_AT + 7]}  = rot128(lk, 45);
      r = rot128(ak, 45);
      sk_nxt[K_AT + 8] = r[127:64];
      r = rot128(lk, 60);
      sk_nxt[K_AT + 9] = r[63:0];
      {sk_nxt[K_AT + 10], sk_nxt[K_AT + 11]} = rot128(ak, 60);
      {sk_nxt[KE_AT + 2], sk_nxt[KE_AT + 3]} = rot128(lk, 77);
      {sk_nxt[K_AT + 12], sk_nxt[K_AT + 13]} = rot128(lk, 94);
      {sk_nxt[K_AT + 14], sk_nxt[K_AT + 15]} = rot128(ak, 94);
      {sk_nxt[K_AT + 16], sk_nxt[K_AT + 17]} = rot128(lk, 111);
      {sk_nxt[KW_AT + 2], sk_nxt[KW_AT + 3]} = rot128(ak, 111);
    end else begin
      r = '0;
      {sk_nxt[K_AT],      sk_nxt[K_AT + 1]}  = bk;
      {sk_nxt[K_AT + 2],  sk_nxt[K_AT + 3]}  = rot128(rk, 15);
      {sk_nxt[K_AT + 4],  sk_nxt[K_AT + 5]}  = rot128(ak, 15);
      {sk_nxt[KE_AT],     sk_nxt[KE_AT + 1]} = rot128(rk, 30);
      {sk_nxt[K_AT + 6],  sk_nxt[K_AT + 7]}  = rot128(bk, 30);
      {sk_nxt[K_AT + 8],  sk_nxt[K_AT + 9]}  = rot128(lk, 45);
      {sk_nxt[K_AT + 10], sk_nxt[K_AT + 11]} = rot128(ak, 45);
      {sk_nxt[KE_AT + 2], sk_nxt[KE_AT + 3]} = rot128(lk, 60);
      {sk_nxt[K_AT + 12], sk_nxt[K_AT + 13]} = rot128(rk, 60);
      {sk_nxt[K_AT + 14], sk_nxt[K_AT + 15]} = rot128(bk, 60);
      {sk_nxt[K_AT + 16], sk_nxt[K_AT + 17]} = rot128(lk, 77);
      {sk_nxt[KE_AT + 4], sk_nxt[KE_AT + 5]} = rot128(ak, 77);
      {sk_nxt[K_AT + 18], sk_nxt[K_AT + 19]} = rot128(rk, 94);
      {sk_nxt[K_AT + 20], sk_nxt[K_AT + 21]} = rot128(ak, 94);
      {sk_nxt[K_AT + 22], sk_nxt[K_AT + 23]} = rot128(lk, 111);
      {sk_nxt[KW_AT + 2], sk_nxt[KW_AT + 3]} = rot128(bk, 111);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == KS_STORE) begin
      sk_r <= sk_nxt;
    end
  end

  assign subkey        = sk_r;
  assign stat.busy     = (state_r != KS_IDLE);
  assign stat.long_key = (size_r != SIZE_128);

`ifndef SYNTHESIS
  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (state_r == KS_LOAD))
    else $error("key write did not restart derivation");
  a_idle_after_store: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(stat.busy) |-> $past(state_r == KS_STORE))
    else $error("derivation left busy without storing subkeys");
`endif

endmodule

### hdl/cam_datapath.sv
// ----------------------------------------------------------------------------
// cam_datapath
// whitening, 24 registered feistel rounds with fl layers, output whitening
// ----------------------------------------------------------------------------
module cam_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_take,
  input  logic                 in_op,
  input  logic [63:0]          in_block_high,
  input  logic [63:0]          in_block_low,
  input  cam_pkg::subkey_arr_t subkey,
  input  cam_pkg::ks_stat_t    stat,
  output logic                 out_valid,
  output logic [63:0]          out_result_high,
  output logic [63:0]          out_result_low
);
  import cam_pkg::*;

  logic [NUM_ROUNDS:0] v_r;
  logic [NUM_ROUNDS:0] dec_r;
  logic [63:0]         d1_r [NUM_ROUNDS + 1];
  logic [63:0]         d2_r [NUM_ROUNDS + 1];
  logic                out_valid_r;
  logic [63:0]         out_high_r, out_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    dec_r[0] <= in_op;
    d1_r[0]  <= in_block_high ^ (in_op ? subkey[KW_AT + 2] : subkey[KW_AT]);
    d2_r[0]  <= in_block_low  ^ (in_op ? subkey[KW_AT + 3] : subkey[KW_AT + 1]);
  end

  for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_rnd
    localparam int  GRP   = i / 6;
    localparam bit  LAYER = ((i % 6) == 5) && (i < NUM_ROUNDS - 1);
    logic [63:0] key, f_out, n1, n2;
    logic        active;

    if (i < 18) begin : g_short
      assign active = 1'b1;
      assign key = !dec_r[i] ? subkey[K_AT + i] :
                   (stat.long_key ? subkey[K_AT + 23 - i] : subkey[K_AT + 17 - i]);
    end else begin : g_long
      // rounds beyond the eighteenth run with long keys only
      assign active = stat.long_key;
      assign key    = dec_r[i] ? subkey[K_AT + 23 - i] : subkey[K_AT + i];
    end

    assign f_out = cam_f((i % 2 == 0) ? d1_r[i] : d2_r[i], key);

    if (LAYER) begin : g_fl
      logic [63:0] ka, kb, r1, r2;
      if (GRP < 2) begin : g_both
        assign ka = !dec_r[i] ? subkey[KE_AT + 2 * GRP] :
                    (stat.long_key ? subkey[KE_AT + 5 - 2 * GRP]
                                   : subkey[KE_AT + 3 - 2 * GRP]);
        assign kb = !dec_r[i] ? subkey[KE_AT + 2 * GRP + 1] :
                    (stat.long_key ? subkey[KE_AT + 4 - 2 * GRP]
                                   : subkey[KE_AT + 2 - 2 * GRP]);
      end else begin : g_third
        assign ka = dec_r[i] ? subkey[KE_AT + 5 - 2 * GRP] : subkey[KE_AT + 2 * GRP];
        assign kb = dec_r[i] ? subkey[KE_AT + 4 - 2 * GRP] : subkey[KE_AT + 2 * GRP + 1];
      end
      assign r1 = d1_r[i] ^ f_out;
      assign r2 = d2_r[i];
      // short keys skip the third layer
      assign n1 = (GRP < 2 || stat.long_key) ? fl_fwd(r1, ka)  : r1;
      assign n2 = (GRP < 2 || stat.long_key) ? fl_back(r2, kb) : r2;
    end else if (i % 2 == 0) begin : g_even
      assign n1 = d1_r[i];
      assign n2 = d2_r[i] ^ f_out;
    end else begin : g_odd
      assign n1 = d1_r[i] ^ f_out;
      assign n2 = d2_r[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i + 1] <= 1'b0;
      end else begin
        v_r[i + 1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      dec_r[i + 1] <= dec_r[i];
      d1_r[i + 1]  <= active ? n1 : d1_r[i];
      d2_r[i + 1]  <= active ? n2 : d2_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_r[NUM_ROUNDS];
    end
  end

  // halves swap on the way out
  always_ff @(posedge clk) begin
    out_high_r <= d2_r[NUM_ROUNDS] ^
                  (dec_r[NUM_ROUNDS] ? subkey[KW_AT] : subkey[KW_AT + 2]);
    out_low_r  <= d1_r[NUM_ROUNDS] ^
                  (dec_r[NUM_ROUNDS] ? subkey[KW_AT + 1] : subkey[KW_AT + 3]);
  end

  assign out_valid       = out_valid_r;
  assign out_result_high = out_high_r;
  assign out_result_low  = out_low_r;

endmodule

### hdl/camellia_block_cipher.sv
// ----------------------------------------------------------------------------
// camellia_block_cipher
// camellia ecb engine, 128/192/256 bit keys, when not busy one block per cycle
// ----------------------------------------------------------------------------
// usage:
//   keys are loaded through cfg_we / cfg_index / cfg_data while the block is
//   idle; registers 0..3 hold the key words, register 4 the key size.
//   each key write starts a subkey derivation (load, six f-function steps
//   on one shared unit, store); busy is high meanwhile.
//   an item is taken at a clock edge with in_start high and busy low;
//   in_op selects encrypt (0) or decrypt (1).
//   the result appears on out_result_high / out_result_low with out_valid
//   high for exactly one cycle, after one whitening stage, 24 round stages
//   (fl layers folded into the last round of each of the first three
//   groups) and one output stage. 128 bit keys pass the last six round
//   stages unchanged, so latency does not depend on key size.
//   a new item may enter on every cycle while busy is low; throughput is one
//   block per cycle. reset clears the keys and then derives subkeys for the
//   all-zero key, so busy is high after reset. results cannot be stalled.
// ----------------------------------------------------------------------------
module camellia_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_start,
  output logic        busy,
  input  logic        in_op,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import cam_pkg::*;

  ks_stat_t    stat;
  subkey_arr_t subkey;
  logic        take;

  assign take = in_start && !stat.busy;
  assign busy = stat.busy;

  cam_key_sched u_key_sched (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .subkey    (subkey)
  );

  cam_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_take         (take),
    .in_op           (in_op),
    .in_block_high   (in_block_high),
    .in_block_low    (in_block_low),
    .subkey          (subkey),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_result_high (out_result_high),
    .out_result_low  (out_result_low)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##26 out_valid)
    else $error("item did not come out after the pipeline latency");
`endif

endmodule

### tb/camellia_block_cipher_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// camellia_block_cipher_checker
// watches key writes, accepted blocks and result blocks of the cipher,
// computes the expected result blocks itself and compares them in order
// ----------------------------------------------------------------------------
module camellia_block_cipher_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_start,
  input  logic        busy,
  input  logic        in_op,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        out_valid,
  input  logic [63:0] out_result_high,
  input  logic [63:0] out_result_low,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          blocks_left,
  output int          blocks_done
);
  import cam_pkg::*;

  logic [63:0] key_w [4];
  logic [1:0]  key_len;
  logic [63:0] subkeys [34];
  logic [127:0] expected_blocks [$];

  function automatic logic [7:0] sb(input logic [7:0] v);
    return SBOX[v];
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  function automatic logic [63:0] feistel(input logic [63:0] x, input logic [63:0] k);
    logic [63:0] y;
    logic [7:0] t [8];
    logic [7:0] z [8];
    y = x ^ k;
    for (int i = 0; i < 8; i++) t[i] = y[63 - 8 * i -: 8];
    t[0] = sb(t[0]);
    t[1] = rotl8(sb(t[1]), 1);
    t[2] = rotl8(sb(t[2]), 7);
    t[3] = sb(rotl8(t[3], 1));
    t[4] = rotl8(sb(t[4]), 1);
    t[5] = rotl8(sb(t[5]), 7);
    t[6] = sb(rotl8(t[6], 1));
    t[7] = sb(t[7]);
    z[0] = t[0] ^ t[2] ^ t[3] ^ t[5] ^ t[6] ^ t[7];
    z[1] = t[0] ^ t[1] ^ t[3] ^ t[4] ^ t[6] ^ t[7];
    z[2] = t[0] ^ t[1] ^ t[2] ^ t[4] ^ t[5] ^ t[7];
    z[3] = t[1] ^ t[2] ^ t[3] ^ t[4] ^ t[5] ^ t[6];
    z[4] = t[0] ^ t[1] ^ t[5] ^ t[6] ^ t[7];
    z[5] = t[1] ^ t[2] ^ t[4] ^ t[6] ^ t[7];
    z[6] = t[2] ^ t[3] ^ t[4] ^ t[5] ^ t[7];
    z[7] = t[0] ^ t[3] ^ t[4] ^ t[5] ^ t[6];
    return {z[0], z[1], z[2], z[3], z[4], z[5], z[6], z[7]};
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v);
    return {v[30:0], v[31]};
  endfunction

  function automatic logic [63:0] layer_fwd(input logic [63:0] x, input logic [63:0] k);
    logic [31:0] a, b;
    a = x[63:32]; b = x[31:0];
    b ^= rotl32(a & k[63:32]);
    a ^= (b | k[31:0]);
    return {a, b};
  endfunction

  function automatic logic [63:0] layer_inv(input logic [63:0] x, input logic [63:0] k);
    logic [31:0] a, b;
    a = x[63:32]; b = x[31:0];
    a ^= (b | k[31:0]);
    b ^= rotl32(a & k[63:32]);
    return {a, b};
  endfunction

  // 128-bit rotation of a key half into one or both store entries
  task automatic put_pair(input int at, input logic [127:0] v, input int n,
                          input bit hi, input bit lo);
    logic [127:0] r;
    r = (n == 0) ? v : ((v << n) | (v >> (128 - n)));
    if (hi) subkeys[at] = r[127:64];
    if (lo) subkeys[at + 1] = r[63:0];
  endtask

  task automatic expand_key();
    logic [63:0] lh, ll, rh, rl, d1, d2;
    logic [127:0] kl, kr, ka, kb;
    lh = key_w[0]; ll = key_w[1]; rh = '0; rl = '0;
    for (int i = 0; i < 34; i++) subkeys[i] = '0;
    if (key_len == SIZE_192) begin
      rh = key_w[2]; rl = ~key_w[2];
    end else if (key_len != SIZE_128) begin
      rh = key_w[2]; rl = key_w[3];
    end
    d1 = lh ^ rh; d2 = ll ^ rl;
    d2 ^= feistel(d1, KEY_CONST[0]);
    d1 ^= feistel(d2, KEY_CONST[1]);
    d1 ^= lh; d2 ^= ll;
    d2 ^= feistel(d1, KEY_CONST[2]);
    d1 ^= feistel(d2, KEY_CONST[3]);
    ka = {d1, d2};
    d1 = d1 ^ rh; d2 = d2 ^ rl;
    d2 ^= feistel(d1, KEY_CONST[4]);
    d1 ^= feistel(d2, KEY_CONST[5]);
    kb = {d1, d2};
    kl = {lh, ll}; kr = {rh, rl};
    subkeys[KW_AT] = lh; subkeys[KW_AT + 1] = ll;
    if (key_len == SIZE_128) begin
      put_pair(K_AT + 0, ka, 0, 1, 1);
      put_pair(K_AT + 2, kl, 15, 1, 1);
      put_pair(K_AT + 4, ka, 15, 1, 1);
      put_pair(KE_AT + 0, ka, 30, 1, 1);
      put_pair(K_AT + 6, kl, 45, 1, 1);
      put_pair(K_AT + 8, ka, 45, 1, 0);
      put_pair(K_AT + 8, kl, 60, 0, 1);
      put_pair(K_AT + 10, ka, 60, 1, 1);
      put_pair(KE_AT + 2, kl, 77, 1, 1);
      put_pair(K_AT + 12, kl, 94, 1, 1);
      put_pair(K_AT + 14, ka, 94, 1, 1);
      put_pair(K_AT + 16, kl, 111, 1, 1);
      put_pair(KW_AT + 2, ka, 111, 1, 1);
    end else begin
      put_pair(K_AT + 0, kb, 0, 1, 1);
      put_pair(K_AT + 2, kr, 15, 1, 1);
      put_pair(K_AT + 4, ka, 15, 1, 1);
      put_pair(KE_AT + 0, kr, 30, 1, 1);
      put_pair(K_AT + 6, kb, 30, 1, 1);
      put_pair(K_AT + 8, kl, 45, 1, 1);
      put_pair(K_AT + 10, ka, 45, 1, 1);
      put_pair(KE_AT + 2, kl, 60, 1, 1);
      put_pair(K_AT + 12, kr, 60, 1, 1);
      put_pair(K_AT + 14, kb, 60, 1, 1);
      put_pair(K_AT + 16, kl, 77, 1, 1);
      put_pair(KE_AT + 4, ka, 77, 1, 1);
      put_pair(K_AT + 18, kr, 94, 1, 1);
      put_pair(K_AT + 20, ka, 94, 1, 1);
      put_pair(K_AT + 22, kl, 111, 1, 1);
      put_pair(KW_AT + 2, kb, 111, 1, 1);
    end
  endtask

  function automatic logic [127:0] cipher_block(input logic dec, input logic [63:0] hi,
                                                 input logic [63:0] lo);
    logic [63:0] d1, d2, k;
    int nk, nfl, i, a, b;
    nk = (key_len == SIZE_128) ? 18 : 24;
    nfl = (key_len == SIZE_128) ? 2 : 3;
    d1 = hi ^ subkeys[KW_AT + (dec ? 2 : 0)];
    d2 = lo ^ subkeys[KW_AT + (dec ? 3 : 1)];
    for (int g = 0; g <= nfl; g++) begin
      for (int r = 0; r < 6; r++) begin
        i = g * 6 + r;
        k = subkeys[K_AT + (dec ? nk - 1 - i : i)];
        if (r % 2 == 0) d2 ^= feistel(d1, k);
        else d1 ^= feistel(d2, k);
      end
      if (g < nfl) begin
        a = 2 * g; b = 2 * g + 1;
        if (dec) begin
          a = 2 * nfl - 1 - a; b = 2 * nfl - 1 - b;
        end
        d1 = layer_fwd(d1, subkeys[KE_AT + a]);
        d2 = layer_inv(d2, subkeys[KE_AT + b]);
      end
    end
    d2 ^= subkeys[KW_AT + (dec ? 0 : 2)];
    d1 ^= subkeys[KW_AT + (dec ? 1 : 3)];
    return {d2, d1};
  endfunction

  assign blocks_left = expected_blocks.size();

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_w[i] = '0;
      key_len = SIZE_128;
      expand_key();
      expected_blocks.delete();
      fail_count <= 0;
      blocks_done <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY0: key_w[0] = cfg_data;
          CFG_KEY1: key_w[1] = cfg_data;
          CFG_KEY2: key_w[2] = cfg_data;
          CFG_KEY3: key_w[3] = cfg_data;
          CFG_SIZE: key_len = cfg_data[1:0];
          default: ;
        endcase
        expand_key();
      end
      if (in_start && !busy)
        expected_blocks.push_back(cipher_block(in_op, in_block_high, in_block_low));
      if (out_valid) begin
        blocks_done <= blocks_done + 1;
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result %h %h", $time, out_result_high, out_result_low);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_blocks.pop_front();
          if (want[127:64] !== out_result_high || want[63:0] !== out_result_low) begin
            $display("%0t: result mismatch, expected %h %h, got %h %h", $time,
                     want[127:64], want[63:0], out_result_high, out_result_low);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### tb/tb_camellia_block_cipher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_camellia_block_cipher
// drives key settings of every size and bursts of encrypt and decrypt
// blocks into the cipher; the checker predicts and compares each result
// ----------------------------------------------------------------------------
module tb_camellia_block_cipher;
  import cam_pkg::*;

  localparam int PIPE_DEPTH = 26;
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_start = 1'b0;
  logic        busy;
  logic        in_op = 1'b0;
  logic [63:0] in_block_high = '0;
  logic [63:0] in_block_low = '0;
  logic        out_valid;
  logic [63:0] out_result_high, out_result_low;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_KEY0;
  logic [63:0] cfg_data = '0;
  int          fail_count, blocks_left, blocks_done;
  int          idle_cycles = 0;
  int          blocks_sent = 0;
  int          key_sets = 0;

  always #1 clk = ~clk;

  camellia_block_cipher uut (.*);

  camellia_block_cipher_checker chk (.*);

  // watchdog: cycles with nothing accepted on either side
  always @(posedge clk) begin
    if ((in_start && !busy) || out_valid || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", idle_cycles);
      $display("tb_camellia_block_cipher: errors");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] edge_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h1;
      default: return rand64();
    endcase
  endfunction

  // wait for pipeline to drain before touching the key
  task automatic drain();
    in_start <= 1'b0;
    @(posedge clk);
    while (blocks_left != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] k0, k1, k2, k3, input logic [1:0] len);
    drain();
    write_reg(CFG_KEY0, k0);
    write_reg(CFG_KEY1, k1);
    write_reg(CFG_KEY2, k2);
    write_reg(CFG_KEY3, k3);
    write_reg(CFG_SIZE, {62'b0, len});
    key_sets++;
  endtask

  // hold one item until accepted
  task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
    in_start <= 1'b1; in_op <= op; in_block_high <= hi; in_block_low <= lo;
    @(posedge clk);
    while (busy) @(posedge clk);
    blocks_sent++;
  endtask

  task automatic random_blocks(input int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      for (int i = 0; i < burst; i++)
        send_block($urandom_range(0, 1), $urandom_range(0, 7) == 0 ? edge_word() : rand64(),
                   $urandom_range(0, 7) == 0 ? edge_word() : rand64());
      left -= burst;
      if ($urandom_range(0, 3) != 0) begin
        in_start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed: reset key, extreme blocks, both directions
    send_block(1'b0, '0, '0);
    send_block(1'b1, '0, '0);
    send_block(1'b0, '1, '1);
    send_block(1'b1, '1, '1);
    // standard 128-bit test key and plaintext
    load_key(64'h0123456789abcdef, 64'hfedcba9876543210, '0, '0, SIZE_128);
    send_block(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(1'b1, 64'h6767313854966973, 64'h0857065648eabe43);
    // 192-bit key: third word complemented, fourth ignored
    load_key(64'h0123456789abcdef, 64'hfedcba9876543210, 64'h0011223344556677, '1, SIZE_192);
    send_block(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(1'b1, '1, '0);
    // 256-bit key
    load_key(64'h0123456789abcdef, 64'hfedcba9876543210, 64'h0011223344556677,
             64'h8899aabbccddeeff, 2'd2);
    send_block(1'b0, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(1'b1, '0, '1);
    // size code three behaves as a 256-bit key
    load_key('1, '1, '1, '1, 2'd3);
    send_block(1'b0, '0, '0);
    send_block(1'b1, 64'h8000000000000000, 64'h1);

    // random phases over key sizes
    for (int ph = 0; ph < 12; ph++) begin
      load_key(edge_word(), edge_word(), edge_word(), edge_word(), 2'($urandom_range(0, 3)));
      random_blocks(75);
    end

    drain();
    $display("ran %0d blocks under %0d key settings, %0d results checked",
             blocks_sent, key_sets, blocks_done);
    if (fail_count == 0) begin
      $display("tb_camellia_block_cipher: clean");
    end else begin
      $display("tb_camellia_block_cipher: errors");
    end
    $finish;
  end

endmodule
